// ===== rtl/core/cdo_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdo_pkg: shared types, constants and calendar functions
// Field widths, command and status codes, reciprocal constants for the
// division-free day-number arithmetic, and the month length and leap tests.
// ============================================================================
package cdo_pkg;

    // Field widths of the streams.
    localparam int YEAR_W   = 14;
    localparam int MON_W    = 4;
    localparam int DAY_W    = 5;
    localparam int CMD_W    = 2;
    localparam int OFF_W    = 17;
    localparam int ERR_W    = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    // Internal widths.
    localparam int YW    = 17;   // year with headroom for sums and compares
    localparam int ERA_W = 6;    // 400-year eras
    localparam int YOE_W = 9;    // year of era, 0..399
    localparam int DOY_W = 9;    // day of March-based year, 0..365
    localparam int DOE_W = 18;   // day of era, 0..146096
    localparam int Z_W   = 24;   // day number from 0000-03-01

    // Largest valid year.
    localparam int MAX_YEAR = 9999;
    localparam logic [YW-1:0] MAX_Y = YW'(MAX_YEAR);

    // Days in a 400-year era and in a plain century.
    localparam longint unsigned ERA_DAYS  = 146097;
    localparam longint unsigned CENT_DAYS = 36524;

    // Rounded-up reciprocals; each is exact over the value range it sees.
    localparam int RCP400_SH  = 23;
    localparam logic [14:0] RCP400  = 15'(((1 << 23) + 399) / 400);
    localparam int RCP12_SH   = 21;
    localparam logic [17:0] RCP12   = 18'(((1 << 21) + 11) / 12);
    localparam int RCPERA_SH  = 40;
    localparam logic [22:0] RCP_ERA = 23'(((64'd1 << 40) + 64'd146096) / 64'd146097);
    localparam int RCP1460_SH = 27;
    localparam logic [16:0] RCP1460 = 17'(((1 << 27) + 1459) / 1460);
    localparam int RCP365_SH  = 27;
    localparam logic [18:0] RCP365  = 19'(((1 << 27) + 364) / 365);
    localparam int RCP153_SH  = 20;
    localparam logic [12:0] RCP153  = 13'(((1 << 20) + 152) / 153);
    localparam int RCP100_SH  = 12;
    localparam logic [5:0]  RCP100  = 6'(((1 << 12) + 99) / 100);

    // Operation selector on the input stream.
    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_MONTHS = 2'd0,
        CMD_ADD_YEARS  = 2'd1,
        CMD_ADD_DAYS   = 2'd2,
        CMD_KEEP       = 2'd3
    } cmd_t;

    // Result status.
    typedef enum logic [ERR_W-1:0] {
        ERR_OK   = 2'd0,
        ERR_DATE = 2'd1,
        ERR_YEAR = 2'd2,
        ERR_NEG  = 2'd3
    } err_t;

    // Per-request status that rides along the day-number pipeline.
    typedef struct packed {
        logic              day_path;
        err_t              err;
        logic [YEAR_W-1:0] year;
        logic [MON_W-1:0]  month;
        logic [DAY_W-1:0]  day;
    } side_t;

    // Multiplicative inverse of an odd number modulo 2^32 by Newton steps.
    function automatic logic [31:0] odd_inverse(input logic [31:0] c);
        logic [31:0] x;
        x = 32'd1;
        for (int i = 0; i < 5; i++) begin
            x = x * (32'd2 - c * x);
        end
        return x;
    endfunction

    localparam logic [YW-1:0] INV25     = YW'(odd_inverse(32'd25));
    localparam logic [YW-1:0] DIV25_LIM = YW'(((1 << YW) - 1) / 25);

    // Leap year test; divisibility by 25 through the modular inverse.
    function automatic logic is_leap(input logic [YW-1:0] y);
        logic [YW-1:0] p;
        logic          div25;
        p     = y * INV25;
        div25 = (p <= DIV25_LIM);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
    endfunction

    // Length of a month; zero for a month number outside the year.
    function automatic logic [DAY_W-1:0] month_days(input logic [YW-1:0] y,
                                                    input logic [MON_W-1:0] m);
        logic [DAY_W-1:0] n;
        unique case (m)
            4'd2:                         n = is_leap(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:      n = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7,
            4'd8, 4'd10, 4'd12:           n = 5'd31;
            default:                      n = 5'd0;
        endcase
        return n;
    endfunction

    // First day of each month in a year that starts in March.
    function automatic logic [DOY_W-1:0] march_start(input logic [MON_W-1:0] mi);
        logic [DOY_W-1:0] s;
        unique case (mi)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/core/calendar_date_offset_unit.sv =====
`timescale 1ns / 1ps
// ============================================================================
// calendar_date_offset_unit: Gregorian date shift by months, years or days
// Validates a start date and keeps it, or moves it by a signed month or year
// count with day clamping, or by a non-negative day count on day numbers.
// ============================================================================
// Usage:
//   Requests enter on the s_ stream: s_tdata carries the start date and the
//   signed offset, s_tuser the command. Each request gives exactly one result
//   on the m_ stream: the new date and a status code, in request order.
//   The path is a 12-stage pipeline (5 front stages for checks and date to
//   day number, 6 stages for day number to date, 1 output register). A
//   request can be taken every cycle while the pipeline is not held, one per
//   cycle.
//   When the receiver holds m_tready low with a result waiting, the whole
//   pipeline holds and s_tready drops; nothing is dropped or repeated.
//   Synchronous reset (aresetn low) clears all valid bits; the first request
//   is taken in the cycle after reset is released.
//   Any error status comes with year, month and day all zero.
// ============================================================================
module calendar_date_offset_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // year[13:0], month[17:14], day[22:18], offset[39:23]
    input  logic [cdo_pkg::S_DATA_W-1:0]   s_tdata,
    // command[1:0]
    input  logic [cdo_pkg::CMD_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // year[13:0], month[17:14], day[22:18], error_code[24:23], zero above
    output logic [cdo_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int YW  = cdo_pkg::YW;
    localparam int YRW = cdo_pkg::YEAR_W;
    localparam int MW  = cdo_pkg::MON_W;
    localparam int DAW = cdo_pkg::DAY_W;
    localparam int OFW = cdo_pkg::OFF_W;
    localparam int DW  = cdo_pkg::DOE_W;
    localparam int EW  = cdo_pkg::ERA_W;
    localparam int OW  = cdo_pkg::YOE_W;
    localparam int ZW  = cdo_pkg::Z_W;
    localparam int DYW = cdo_pkg::DOY_W;

    logic adv;

    // Input fields.
    logic [YRW-1:0]        in_year;
    logic [MW-1:0]         in_month;
    logic [DAW-1:0]        in_day;
    logic signed [OFW-1:0] in_off;
    cdo_pkg::cmd_t         in_cmd;
    logic [DAW-1:0]        in_lim;
    logic                  in_bad;
    logic [YRW-1:0]        in_ymar;
    logic [MW-1:0]         in_mi;
    logic [17:0]           in_y12;
    logic signed [19:0]    in_tot;
    logic signed [18:0]    in_ysum;

    // Stage 1 registers.
    logic                  v1_reg;
    logic [YRW-1:0]        y1_reg, ymar1_reg;
    logic [MW-1:0]         m1_reg, mi1_reg;
    logic [DAW-1:0]        d1_reg;
    cdo_pkg::cmd_t         cmd1_reg;
    logic signed [OFW-1:0] off1_reg;
    logic                  bad1_reg;
    logic signed [19:0]    tot1_reg;
    logic signed [18:0]    ysum1_reg;

    // Stage 2 registers.
    logic                  v2_reg;
    logic [YRW-1:0]        y2_reg, ymar2_reg;
    logic [MW-1:0]         m2_reg, mi2_reg;
    logic [DAW-1:0]        d2_reg;
    cdo_pkg::cmd_t         cmd2_reg;
    logic signed [OFW-1:0] off2_reg;
    logic                  bad2_reg, mlow2_reg, ybad2_reg;
    logic [EW-1:0]         era2_reg;
    logic [YW-1:0]         ny2_reg, ysum2_reg;
    logic [17:0]           totl2_reg;
    logic [28:0]           p400;
    logic [35:0]           p12;

    // Stage 3 registers.
    logic                  v3_reg;
    logic [YW-1:0]         ty3_reg;
    logic [MW-1:0]         tm3_reg, mi3_reg;
    logic [DAW-1:0]        d3_reg;
    cdo_pkg::err_t         err3_reg;
    logic                  day3_reg;
    logic [OW-1:0]         yoe3_reg;
    logic [EW-1:0]         era3_reg;
    logic [15:0]           off3_reg;
    logic [YW-1:0]         ty3_next;
    logic [MW-1:0]         tm3_next;
    cdo_pkg::err_t         err3_next;
    logic [17:0]           mrem;

    // Stage 4 and 5 registers.
    logic                  v4_reg, v5_reg;
    cdo_pkg::side_t        side4_reg, side5_reg, side4_next;
    logic [DW-1:0]         doe4_reg;
    logic [22:0]           ep4_reg;
    logic [15:0]           off4_reg;
    logic [ZW-1:0]         z5_reg;
    logic [DAW-1:0]        lim4, dy4;
    logic [14:0]           yq4;

    // Back end and output stage.
    logic                  b_valid;
    cdo_pkg::side_t        b_side;
    logic [YW-1:0]         b_year;
    logic [DYW-1:0]        b_doy;
    logic [MW-1:0]         b_mp;
    logic [MW-1:0]         f_mon;
    logic [DYW-1:0]        f_day;
    logic [YW-1:0]         f_year;
    cdo_pkg::side_t        f_res;
    logic                  m_valid_reg;
    logic [cdo_pkg::M_DATA_W-1:0] m_data_reg;

    // The pipeline moves whenever the output register is free or drained.
    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    // Stage 1: field split, start-date check and offset sums.
    assign in_year  = s_tdata[13:0];
    assign in_month = s_tdata[17:14];
    assign in_day   = s_tdata[22:18];
    assign in_off   = $signed(s_tdata[39:23]);
    assign in_cmd   = cdo_pkg::cmd_t'(s_tuser);
    assign in_lim   = cdo_pkg::month_days(YW'(in_year), in_month);
    assign in_bad   = (in_year == '0) || (YW'(in_year) > cdo_pkg::MAX_Y) ||
                      (in_month == '0) || (in_month > 4'd12) ||
                      (in_day == '0) || (in_day > in_lim);
    assign in_ymar  = (in_month <= 4'd2) ? in_year - 14'd1 : in_year;
    assign in_mi    = (in_month >= 4'd3) ? in_month - 4'd3 : in_month + 4'd9;
    assign in_y12   = {1'b0, in_year, 3'b000} + {2'b00, in_year, 2'b00};
    assign in_tot   = $signed({2'b00, in_y12}) + $signed({16'd0, in_month - 4'd1})
                      + 20'(in_off);
    assign in_ysum  = $signed({5'd0, in_year}) + 19'(in_off);

    // Stage 2: era of the start year and year of the month sum.
    assign p400 = 29'(ymar1_reg) * 29'(cdo_pkg::RCP400);
    assign p12  = 36'(tot1_reg[17:0]) * 36'(cdo_pkg::RCP12);

    // Stage 3: year of era, month remainder and target of the clamp.
    assign mrem = totl2_reg - 18'(ny2_reg) * 18'd12;

    always_comb begin
        unique case (cmd2_reg)
            cdo_pkg::CMD_ADD_MONTHS: begin
                ty3_next  = ny2_reg;
                tm3_next  = mrem[3:0] + 4'd1;
                err3_next = (mlow2_reg || (ny2_reg > cdo_pkg::MAX_Y)) ?
                            cdo_pkg::ERR_YEAR : cdo_pkg::ERR_OK;
            end
            cdo_pkg::CMD_ADD_YEARS: begin
                ty3_next  = ysum2_reg;
                tm3_next  = m2_reg;
                err3_next = ybad2_reg ? cdo_pkg::ERR_YEAR : cdo_pkg::ERR_OK;
            end
            cdo_pkg::CMD_ADD_DAYS: begin
                ty3_next  = YW'(y2_reg);
                tm3_next  = m2_reg;
                err3_next = (off2_reg < 0) ? cdo_pkg::ERR_NEG : cdo_pkg::ERR_OK;
            end
            default: begin
                ty3_next  = YW'(y2_reg);
                tm3_next  = m2_reg;
                err3_next = cdo_pkg::ERR_OK;
            end
        endcase
        if (bad2_reg) begin
            err3_next = cdo_pkg::ERR_DATE;
        end
    end

    // Stage 4: day clamp for month and year shifts, day of era of the start.
    assign lim4 = cdo_pkg::month_days(ty3_reg, tm3_reg);
    assign dy4  = (d3_reg > lim4) ? lim4 : d3_reg;
    assign yq4  = 15'(yoe3_reg) * 15'(cdo_pkg::RCP100);

    always_comb begin
        side4_next.day_path = day3_reg && (err3_reg == cdo_pkg::ERR_OK);
        side4_next.err      = err3_reg;
        if (err3_reg == cdo_pkg::ERR_OK) begin
            side4_next.year  = ty3_reg[YRW-1:0];
            side4_next.month = tm3_reg;
            side4_next.day   = dy4;
        end else begin
            side4_next.year  = '0;
            side4_next.month = '0;
            side4_next.day   = '0;
        end
    end

    // Valid bits of the front stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Front stage payloads.
    always_ff @(posedge aclk) begin
        if (adv) begin
            y1_reg    <= in_year;
            m1_reg    <= in_month;
            d1_reg    <= in_day;
            cmd1_reg  <= in_cmd;
            off1_reg  <= in_off;
            bad1_reg  <= in_bad;
            ymar1_reg <= in_ymar;
            mi1_reg   <= in_mi;
            tot1_reg  <= in_tot;
            ysum1_reg <= in_ysum;

            y2_reg    <= y1_reg;
            m2_reg    <= m1_reg;
            d2_reg    <= d1_reg;
            cmd2_reg  <= cmd1_reg;
            off2_reg  <= off1_reg;
            bad2_reg  <= bad1_reg;
            ymar2_reg <= ymar1_reg;
            mi2_reg   <= mi1_reg;
            era2_reg  <= p400[28:cdo_pkg::RCP400_SH];
            ny2_reg   <= YW'(p12[35:cdo_pkg::RCP12_SH]);
            totl2_reg <= tot1_reg[17:0];
            mlow2_reg <= (tot1_reg < 20'sd12);
            ybad2_reg <= (ysum1_reg < 19'sd1) ||
                         (ysum1_reg > $signed({2'b00, cdo_pkg::MAX_Y}));
            ysum2_reg <= ysum1_reg[YW-1:0];

            ty3_reg   <= ty3_next;
            tm3_reg   <= tm3_next;
            d3_reg    <= d2_reg;
            err3_reg  <= err3_next;
            day3_reg  <= (cmd2_reg == cdo_pkg::CMD_ADD_DAYS);
            yoe3_reg  <= OW'(ymar2_reg - YRW'(era2_reg) * YRW'(400));
            mi3_reg   <= mi2_reg;
            era3_reg  <= era2_reg;
            off3_reg  <= off2_reg[15:0];

            side4_reg <= side4_next;
            doe4_reg  <= DW'(yoe3_reg) * DW'(365) + DW'(yoe3_reg[OW-1:2])
                         - DW'(yq4[14:cdo_pkg::RCP100_SH])
                         + DW'(cdo_pkg::march_start(mi3_reg)) + DW'(d3_reg) - DW'(1);
            ep4_reg   <= 23'(era3_reg) * 23'(cdo_pkg::ERA_DAYS);
            off4_reg  <= off3_reg;

            side5_reg <= side4_reg;
            z5_reg    <= ZW'(ep4_reg) + ZW'(doe4_reg) + ZW'(off4_reg);
        end
    end

    // Day number back to a date.
    cdo_day_to_date u_day_to_date (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v5_reg),
        .in_z      (z5_reg),
        .in_side   (side5_reg),
        .out_valid (b_valid),
        .out_side  (b_side),
        .out_year  (b_year),
        .out_doy   (b_doy),
        .out_mp    (b_mp)
    );

    // Output stage: finish the day-path date and pick the result.
    assign f_mon  = (b_mp < 4'd10) ? b_mp + 4'd3 : b_mp - 4'd9;
    assign f_day  = b_doy - cdo_pkg::march_start(b_mp) + 9'd1;
    assign f_year = b_year + ((f_mon <= 4'd2) ? YW'(1) : YW'(0));

    always_comb begin
        f_res = b_side;
        if (b_side.day_path) begin
            if (f_year > cdo_pkg::MAX_Y) begin
                f_res.err   = cdo_pkg::ERR_YEAR;
                f_res.year  = '0;
                f_res.month = '0;
                f_res.day   = '0;
            end else begin
                f_res.err   = cdo_pkg::ERR_OK;
                f_res.year  = f_year[YRW-1:0];
                f_res.month = f_mon;
                f_res.day   = f_day[DAW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= b_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= {7'd0, f_res.err, f_res.day, f_res.month, f_res.year};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // Any error status carries an all-zero date.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[24:23] != cdo_pkg::ERR_OK)) |-> (m_tdata[22:0] == '0))
        else $error("error result with a nonzero date");

    // A good result has a nonzero year and a month in range.
    a_ok_month: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[24:23] == cdo_pkg::ERR_OK)) |->
        ((m_tdata[13:0] != '0) && (m_tdata[17:14] >= 4'd1) && (m_tdata[17:14] <= 4'd12)))
        else $error("good result with year or month out of range");

    // A good result has a day inside its month.
    a_ok_day: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[24:23] == cdo_pkg::ERR_OK)) |->
        ((m_tdata[22:18] != '0) &&
         (m_tdata[22:18] <= cdo_pkg::month_days(YW'(m_tdata[13:0]), m_tdata[17:14]))))
        else $error("good result with day outside its month");
`endif

endmodule

// ===== rtl/core/cdo_day_to_date.sv =====
`timescale 1ns / 1ps
// ============================================================================
// cdo_day_to_date: day number to calendar date pipeline
// Six register stages split a day number into era, day of era, year of era,
// day of year and March-based month.
// ============================================================================
module cdo_day_to_date (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [cdo_pkg::Z_W-1:0]       in_z,
    input  cdo_pkg::side_t                in_side,
    output logic                          out_valid,
    output cdo_pkg::side_t                out_side,
    output logic [cdo_pkg::YW-1:0]        out_year,
    output logic [cdo_pkg::DOY_W-1:0]     out_doy,
    output logic [cdo_pkg::MON_W-1:0]     out_mp
);

    localparam int ZW  = cdo_pkg::Z_W;
    localparam int DW  = cdo_pkg::DOE_W;
    localparam int EW  = cdo_pkg::ERA_W;
    localparam int OW  = cdo_pkg::YOE_W;
    localparam int YW  = cdo_pkg::YW;
    localparam int DYW = cdo_pkg::DOY_W;

    logic [5:0] v_reg;

    cdo_pkg::side_t side6_reg, side7_reg, side8_reg, side9_reg, side10_reg, side11_reg;
    logic [ZW-1:0]  z6_reg;
    logic [EW-1:0]  era6_reg, era7_reg, era8_reg, era9_reg;
    logic [DW-1:0]  doe7_reg, doe8_reg, doe9_reg;
    logic [DW-1:0]  t8_reg;
    logic [OW-1:0]  yoe9_reg;
    logic [DYW-1:0] doy10_reg, doy11_reg;
    logic [YW-1:0]  yb10_reg, yb11_reg;
    logic [3:0]     mp11_reg;

    logic [46:0]    p_era;
    logic [ZW-1:0]  era_days;
    logic [34:0]    p1460;
    logic [2:0]     q_cent;
    logic           q_last;
    logic [DW-1:0]  t8_next;
    logic [36:0]    p365;
    logic [14:0]    yq10;
    logic [10:0]    x11;
    logic [23:0]    p153;

    // Era estimate from the reciprocal of the era length.
    assign p_era = 47'(in_z) * 47'(cdo_pkg::RCP_ERA);

    // Day of era.
    assign era_days = ZW'(era6_reg) * ZW'(cdo_pkg::ERA_DAYS);

    // Leap-day correction terms before the year-of-era division.
    assign p1460 = 35'(doe7_reg) * 35'(cdo_pkg::RCP1460);

    always_comb begin
        priority if (doe7_reg >= DW'(4 * cdo_pkg::CENT_DAYS)) begin
            q_cent = 3'd4;
        end else if (doe7_reg >= DW'(3 * cdo_pkg::CENT_DAYS)) begin
            q_cent = 3'd3;
        end else if (doe7_reg >= DW'(2 * cdo_pkg::CENT_DAYS)) begin
            q_cent = 3'd2;
        end else if (doe7_reg >= DW'(cdo_pkg::CENT_DAYS)) begin
            q_cent = 3'd1;
        end else begin
            q_cent = 3'd0;
        end
    end

    assign q_last  = (doe7_reg == DW'(cdo_pkg::ERA_DAYS - 1));
    assign t8_next = doe7_reg - DW'(p1460[34:cdo_pkg::RCP1460_SH])
                     + DW'(q_cent) - DW'(q_last);

    // Year of era.
    assign p365 = 37'(t8_reg) * 37'(cdo_pkg::RCP365);

    // Day of the March-based year.
    assign yq10 = 15'(yoe9_reg) * 15'(cdo_pkg::RCP100);

    // Month index of the March-based year.
    assign x11  = 11'(doy10_reg) * 11'd5 + 11'd2;
    assign p153 = 24'(x11) * 24'(cdo_pkg::RCP153);

    // Valid bits of the six stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    // Stage payloads.
    always_ff @(posedge aclk) begin
        if (adv) begin
            side6_reg  <= in_side;
            z6_reg     <= in_z;
            era6_reg   <= p_era[45:cdo_pkg::RCPERA_SH];

            side7_reg  <= side6_reg;
            era7_reg   <= era6_reg;
            doe7_reg   <= DW'(z6_reg - era_days);

            side8_reg  <= side7_reg;
            era8_reg   <= era7_reg;
            doe8_reg   <= doe7_reg;
            t8_reg     <= t8_next;

            side9_reg  <= side8_reg;
            era9_reg   <= era8_reg;
            doe9_reg   <= doe8_reg;
            yoe9_reg   <= p365[35:cdo_pkg::RCP365_SH];

            side10_reg <= side9_reg;
            doy10_reg  <= DYW'(doe9_reg - (DW'(yoe9_reg) * DW'(365) + DW'(yoe9_reg[OW-1:2])
                              - DW'(yq10[14:cdo_pkg::RCP100_SH])));
            yb10_reg   <= YW'(era9_reg) * YW'(400) + YW'(yoe9_reg);

            side11_reg <= side10_reg;
            doy11_reg  <= doy10_reg;
            yb11_reg   <= yb10_reg;
            mp11_reg   <= p153[23:cdo_pkg::RCP153_SH];
        end
    end

    assign out_valid = v_reg[5];
    assign out_side  = side11_reg;
    assign out_year  = yb11_reg;
    assign out_doy   = doy11_reg;
    assign out_mp    = mp11_reg;

endmodule
